// ----- sv/sqt_pkg.sv -----
// ----------------------------------------------------------------------------
// sqt_pkg
// shared types and constants of the query text tokenizer
// ----------------------------------------------------------------------------
package sqt_pkg;

    localparam int POSITION_BITS_DEF     = 16;
    localparam int KEYWORD_MAX_CHARS_DEF = 6;

    localparam logic [5:0] K_LPAR   = 6'd8;
    localparam logic [5:0] K_RPAR   = 6'd9;
    localparam logic [5:0] K_PLUS   = 6'd10;
    localparam logic [5:0] K_MINUS  = 6'd11;
    localparam logic [5:0] K_STAR   = 6'd12;
    localparam logic [5:0] K_COMMA  = 6'd13;
    localparam logic [5:0] K_SLASH  = 6'd14;
    localparam logic [5:0] K_EQ     = 6'd15;
    localparam logic [5:0] K_GE     = 6'd21;
    localparam logic [5:0] K_LE     = 6'd22;
    localparam logic [5:0] K_GT     = 6'd23;
    localparam logic [5:0] K_LT     = 6'd24;
    localparam logic [5:0] K_NE     = 6'd36;
    localparam logic [5:0] K_NUMBER = 6'd37;
    localparam logic [5:0] K_IDENT  = 6'd38;
    localparam logic [5:0] K_STRING = 6'd39;

    localparam logic [2:0] G_NONE    = 3'd0;
    localparam logic [2:0] G_SPECIAL = 3'd2;
    localparam logic [2:0] G_ARITH   = 3'd3;
    localparam logic [2:0] G_REL     = 3'd4;
    localparam logic [2:0] G_LITERAL = 3'd6;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNEXP    = 2'd1;
    localparam logic [1:0] E_UNCLOSED = 2'd2;

    typedef enum logic [7:0] {
        M_IDLE   = 8'b0000_0001,
        M_NUMBER = 8'b0000_0010,
        M_WORD   = 8'b0000_0100,
        M_STRING = 8'b0000_1000,
        M_GT     = 8'b0001_0000,
        M_BANG   = 8'b0010_0000,
        M_EQ     = 8'b0100_0000,
        M_DROP   = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  group;
        logic [15:0] start;
        logic [15:0] length;
        logic [1:0]  err;
    } token_t;

    localparam int NUM_KW = 25;

    typedef struct packed {
        logic [63:0] name;   // first char in low byte, zero padded
        logic [3:0]  len;
        logic [5:0]  kind;
        logic [2:0]  group;
    } kw_t;

    function automatic kw_t kw_entry(input int i);
        kw_t e;
        unique case (i)
            0:  e = '{64'h0000_5443_454C_4553, 4'd6, 6'd0,  3'd0};
            1:  e = '{64'h0000_5452_4553_4E49, 4'd6, 6'd1,  3'd0};
            2:  e = '{64'h0000_4554_454C_4544, 4'd6, 6'd2,  3'd0};
            3:  e = '{64'h0000_4554_4144_5055, 4'd6, 6'd3,  3'd0};
            4:  e = '{64'h0000_0000_4D4F_5246, 4'd4, 6'd4,  3'd0};
            5:  e = '{64'h0000_0045_5245_4857, 4'd5, 6'd5,  3'd0};
            6:  e = '{64'h0000_0000_0044_4E41, 4'd3, 6'd6,  3'd1};
            7:  e = '{64'h0000_0000_0000_524F, 4'd2, 6'd7,  3'd1};
            8:  e = '{64'h0000_0052_4550_5055, 4'd5, 6'd16, 3'd5};
            9:  e = '{64'h0000_0052_4557_4F4C, 4'd5, 6'd17, 3'd5};
            10: e = '{64'h0000_0000_0058_414D, 4'd3, 6'd18, 3'd5};
            11: e = '{64'h0000_0000_004E_494D, 4'd3, 6'd19, 3'd5};
            12: e = '{64'h0000_0000_0047_5641, 4'd3, 6'd20, 3'd5};
            13: e = '{64'h0000_0000_4555_5254, 4'd4, 6'd25, 3'd6};
            14: e = '{64'h0000_0045_534C_4146, 4'd5, 6'd25, 3'd6};
            15: e = '{64'h0000_0000_0000_5341, 4'd2, 6'd26, 3'd0};
            16: e = '{64'h0000_0052_4544_524F, 4'd5, 6'd27, 3'd0};
            17: e = '{64'h0000_0000_0000_5942, 4'd2, 6'd28, 3'd0};
            18: e = '{64'h0000_0000_0043_5341, 4'd3, 6'd29, 3'd0};
            19: e = '{64'h0000_0000_4353_4544, 4'd4, 6'd30, 3'd0};
            20: e = '{64'h0000_0054_494D_494C, 4'd5, 6'd31, 3'd0};
            21: e = '{64'h0000_0000_454B_494C, 4'd4, 6'd32, 3'd4};
            22: e = '{64'h0000_0050_554F_5247, 4'd5, 6'd33, 3'd0};
            23: e = '{64'h0000_0000_0054_4F4E, 4'd3, 6'd34, 3'd7};
            24: e = '{64'h0000_0000_4554_4144, 4'd4, 6'd35, 3'd5};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ----- sv/sql_query_tokenizer.sv -----
// ----------------------------------------------------------------------------
// sql_query_tokenizer
// streaming lexer: query text bytes in, tokens out
// ----------------------------------------------------------------------------
// One text byte is taken per cycle and gives zero, one or two tokens. Tokens
// are classified combinationally from the scan state and the registered byte,
// including a parallel compare of the buffered word against all keywords, and
// go into a two-entry result register. A byte is taken whenever that register
// has room for two tokens, so sustained rate is one byte per cycle as long as
// tokens are drained at one per cycle; a byte that ends two tokens at once
// holds the next byte back until the register has room for two tokens again.
module sql_query_tokenizer #(
    parameter int POSITION_BITS     = sqt_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = sqt_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [2:0]  token_class,
    output logic [15:0] text_start,
    output logic [15:0] text_length,
    output logic [1:0]  error_code,
    output logic        statement_end,
    output logic        run_last
);

    localparam int PB = POSITION_BITS;
    localparam int KB = $clog2(KEYWORD_MAX_CHARS);

    typedef logic [PB-1:0] pos_t;

    // input register
    logic       iv_reg;
    logic [7:0] ib_reg;
    logic       il_reg;

    // scan state
    sqt_pkg::mode_t mode_reg, mode_next;
    logic [7:0] wbuf_reg [KEYWORD_MAX_CHARS];
    logic       wlong_reg, wlong_next;
    pos_t       tbeg_reg, tbeg_next;
    pos_t       bpos_reg, bpos_next;

    // result queue, two entries
    sqt_pkg::token_t q_tok_reg [2];
    logic            q_se_reg  [2];
    logic            q_rl_reg  [2];
    logic [1:0]      q_cnt_reg;
    logic            q_head_reg;

    logic process;
    logic pop;
    logic [1:0] free_slots;

    assign pop        = out_valid && out_ready;
    assign free_slots = 2'd2 - q_cnt_reg;
    // the held byte is processed only if two tokens would fit
    assign process    = iv_reg && (free_slots == 2'd2 || (pop && q_cnt_reg == 2'd1));
    assign in_ready   = !iv_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ib_reg <= text_byte;
            il_reg <= end_of_text;
        end
    end

    // byte classes
    logic [7:0] c;
    logic is_letter, is_digit, word_char;
    assign c         = ib_reg;
    assign is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit  = c >= 8'h30 && c <= 8'h39;
    assign word_char = is_letter || c == 8'h5F;

    pos_t pos, span, span_last;
    assign pos       = bpos_reg;
    assign span      = pos - tbeg_reg;

    function automatic logic [15:0] w16(input pos_t v);
        logic [31:0] t;
        t = 32'(v);
        return t[15:0];
    endfunction

    // word match against keywords
    function automatic sqt_pkg::token_t word_tok(input pos_t len, input logic lng,
                                                 input pos_t beg,
                                                 input logic [8*KEYWORD_MAX_CHARS-1:0] buf_v);
        sqt_pkg::token_t t;
        sqt_pkg::kw_t    e;
        logic            hit;
        t   = '{sqt_pkg::K_IDENT, sqt_pkg::G_LITERAL, w16(beg), w16(len), sqt_pkg::E_NONE};
        hit = 1'b0;
        for (int i = 0; i < sqt_pkg::NUM_KW; i++)
        begin
            e = sqt_pkg::kw_entry(i);
            if (!hit && !lng && len == pos_t'(e.len)
                && (((buf_v ^ (8*KEYWORD_MAX_CHARS)'(e.name))
                     & ~({8*KEYWORD_MAX_CHARS{1'b1}} << (8*32'(e.len)))) == '0))
            begin
                hit     = 1'b1;
                t.kind  = e.kind;
                t.group = e.group;
            end
        end
        return t;
    endfunction

    logic [8*KEYWORD_MAX_CHARS-1:0] wflat, wflat_upd;
    logic [7:0] folded;
    logic       store_ok;
    logic       wlong_upd;
    assign folded = is_letter ? (c & 8'hDF) : c;

    always_comb
    begin
        for (int i = 0; i < KEYWORD_MAX_CHARS; i++)
        begin
            wflat[8*i +: 8] = wbuf_reg[i];
        end
    end

    sqt_pkg::token_t r_tok [2];
    logic            r_v   [2];
    logic            fresh;
    logic [KB-1:0]   widx;
    logic            wwe;
    sqt_pkg::mode_t  m1;
    pos_t            tb1;
    sqt_pkg::token_t t0, t1;
    logic            v0, v1;

    always_comb
    begin
        t0 = '0; t1 = '0; v0 = 1'b0; v1 = 1'b0;
        fresh = 1'b0;
        m1 = mode_reg;
        tb1 = tbeg_reg;
        wlong_upd = wlong_reg;
        wflat_upd = wflat;
        wwe = 1'b0;
        widx = '0;
        store_ok = 1'b0;
        unique case (mode_reg)
            sqt_pkg::M_DROP: ;
            sqt_pkg::M_STRING:
            begin
                if (c == 8'h22)
                begin
                    t0 = '{sqt_pkg::K_STRING, sqt_pkg::G_LITERAL, w16(tbeg_reg + pos_t'(1)),
                           w16(span - pos_t'(1)), sqt_pkg::E_NONE};
                    v0 = 1'b1;
                    m1 = sqt_pkg::M_IDLE;
                end
            end
            sqt_pkg::M_NUMBER:
            begin
                if (!(is_digit || c == 8'h2E))
                begin
                    t0 = '{sqt_pkg::K_NUMBER, sqt_pkg::G_LITERAL, w16(tbeg_reg), w16(span),
                           sqt_pkg::E_NONE};
                    v0 = 1'b1;
                    fresh = 1'b1;
                end
            end
            sqt_pkg::M_WORD:
            begin
                if (word_char)
                begin
                    if (span < pos_t'(KEYWORD_MAX_CHARS))
                    begin
                        store_ok = 1'b1;
                        widx = span[KB-1:0];
                        wflat_upd[8*32'(widx) +: 8] = folded;
                    end
                    else
                    begin
                        wlong_upd = 1'b1;
                    end
                end
                else
                begin
                    t0 = word_tok(span, wlong_reg, tbeg_reg, wflat);
                    v0 = 1'b1;
                    fresh = 1'b1;
                end
            end
            sqt_pkg::M_GT:
            begin
                v0 = 1'b1;
                if (c == 8'h3D)
                begin
                    t0 = '{sqt_pkg::K_GE, sqt_pkg::G_REL, w16(tbeg_reg), 16'd2, sqt_pkg::E_NONE};
                    m1 = sqt_pkg::M_IDLE;
                end
                else
                begin
                    t0 = '{sqt_pkg::K_GT, sqt_pkg::G_REL, w16(tbeg_reg), 16'd1, sqt_pkg::E_NONE};
                    fresh = 1'b1;
                end
            end
            sqt_pkg::M_BANG:
            begin
                v0 = 1'b1;
                if (c == 8'h3D)
                begin
                    t0 = '{sqt_pkg::K_NE, sqt_pkg::G_REL, w16(tbeg_reg), 16'd2, sqt_pkg::E_NONE};
                    m1 = sqt_pkg::M_IDLE;
                end
                else
                begin
                    t0 = '{6'd0, sqt_pkg::G_NONE, w16(tbeg_reg), 16'd0, sqt_pkg::E_UNEXP};
                    m1 = sqt_pkg::M_DROP;
                end
            end
            sqt_pkg::M_EQ:
            begin
                v0 = 1'b1;
                if (c == 8'h3C)
                begin
                    t0 = '{sqt_pkg::K_LE, sqt_pkg::G_REL, w16(tbeg_reg), 16'd2, sqt_pkg::E_NONE};
                    m1 = sqt_pkg::M_IDLE;
                end
                else
                begin
                    t0 = '{sqt_pkg::K_EQ, sqt_pkg::G_REL, w16(tbeg_reg), 16'd1, sqt_pkg::E_NONE};
                    fresh = 1'b1;
                end
            end
            default: fresh = 1'b1;
        endcase

        if (fresh)
        begin
            m1  = sqt_pkg::M_IDLE;
            tb1 = pos;
            t1  = '{6'd0, sqt_pkg::G_NONE, w16(pos), 16'd1, sqt_pkg::E_NONE};
            priority if (is_digit)
                m1 = sqt_pkg::M_NUMBER;
            else if (is_letter)
            begin
                m1 = sqt_pkg::M_WORD;
                wlong_upd = 1'b0;
                store_ok = 1'b1;
                widx = '0;
                wflat_upd[7:0] = folded;
            end
            else if (c == 8'h22)
                m1 = sqt_pkg::M_STRING;
            else if (c == 8'h28) begin t1.kind = sqt_pkg::K_LPAR;  t1.group = sqt_pkg::G_SPECIAL; v1 = 1'b1; end
            else if (c == 8'h29) begin t1.kind = sqt_pkg::K_RPAR;  t1.group = sqt_pkg::G_SPECIAL; v1 = 1'b1; end
            else if (c == 8'h2C) begin t1.kind = sqt_pkg::K_COMMA; t1.group = sqt_pkg::G_SPECIAL; v1 = 1'b1; end
            else if (c == 8'h2D) begin t1.kind = sqt_pkg::K_MINUS; t1.group = sqt_pkg::G_SPECIAL; v1 = 1'b1; end
            else if (c == 8'h2B) begin t1.kind = sqt_pkg::K_PLUS;  t1.group = sqt_pkg::G_ARITH;   v1 = 1'b1; end
            else if (c == 8'h2A) begin t1.kind = sqt_pkg::K_STAR;  t1.group = sqt_pkg::G_ARITH;   v1 = 1'b1; end
            else if (c == 8'h2F) begin t1.kind = sqt_pkg::K_SLASH; t1.group = sqt_pkg::G_ARITH;   v1 = 1'b1; end
            else if (c == 8'h3C) begin t1.kind = sqt_pkg::K_LT;    t1.group = sqt_pkg::G_REL;     v1 = 1'b1; end
            else if (c == 8'h3E)
                m1 = sqt_pkg::M_GT;
            else if (c == 8'h21)
                m1 = sqt_pkg::M_BANG;
            else if (c == 8'h3D)
                m1 = sqt_pkg::M_EQ;
            else if (c != 8'h20)
            begin
                t1 = '{6'd0, sqt_pkg::G_NONE, w16(pos), 16'd0, sqt_pkg::E_UNEXP};
                v1 = 1'b1;
                m1 = sqt_pkg::M_DROP;
            end
            else
                m1 = sqt_pkg::M_IDLE;
        end

        // length of the pending token including this byte
        span_last = pos + pos_t'(1) - tb1;

        // end of text flush
        if (il_reg)
        begin
            unique case (m1)
                sqt_pkg::M_NUMBER:
                begin
                    t1 = '{sqt_pkg::K_NUMBER, sqt_pkg::G_LITERAL, w16(tb1), w16(span_last),
                           sqt_pkg::E_NONE};
                    v1 = 1'b1;
                end
                sqt_pkg::M_WORD:
                begin
                    t1 = word_tok(span_last, wlong_upd, tb1, wflat_upd);
                    v1 = 1'b1;
                end
                sqt_pkg::M_STRING:
                begin
                    t1 = '{6'd0, sqt_pkg::G_NONE, w16(tb1), 16'd0, sqt_pkg::E_UNCLOSED};
                    v1 = 1'b1;
                end
                sqt_pkg::M_GT:
                begin
                    t1 = '{sqt_pkg::K_GT, sqt_pkg::G_REL, w16(tb1), 16'd1, sqt_pkg::E_NONE};
                    v1 = 1'b1;
                end
                sqt_pkg::M_EQ:
                begin
                    t1 = '{sqt_pkg::K_EQ, sqt_pkg::G_REL, w16(tb1), 16'd1, sqt_pkg::E_NONE};
                    v1 = 1'b1;
                end
                sqt_pkg::M_BANG:
                begin
                    t1 = '{6'd0, sqt_pkg::G_NONE, w16(tb1), 16'd0, sqt_pkg::E_UNEXP};
                    v1 = 1'b1;
                end
                default: ;
            endcase
            mode_next  = sqt_pkg::M_IDLE;
            wlong_next = 1'b0;
            tbeg_next  = '0;
            bpos_next  = '0;
        end
        else
        begin
            mode_next  = m1;
            wlong_next = wlong_upd;
            tbeg_next  = tb1;
            bpos_next  = pos + pos_t'(1);
        end
        wwe = store_ok;

        // compact the two slots
        if (v0)
        begin
            r_tok[0] = t0; r_v[0] = 1'b1;
            r_tok[1] = t1; r_v[1] = v1;
        end
        else
        begin
            r_tok[0] = t1; r_v[0] = v1;
            r_tok[1] = t1; r_v[1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sqt_pkg::M_IDLE;
            wlong_reg <= 1'b0;
            tbeg_reg  <= '0;
            bpos_reg  <= '0;
        end
        else if (process)
        begin
            mode_reg  <= mode_next;
            wlong_reg <= wlong_next;
            tbeg_reg  <= tbeg_next;
            bpos_reg  <= bpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && wwe)
        begin
            wbuf_reg[widx] <= folded;
        end
    end

    // result queue
    logic [1:0] n_new;
    logic       tail;
    logic [1:0] cnt_after_pop;
    logic       head_after_pop;
    assign n_new          = process ? (2'(r_v[0]) + 2'(r_v[1])) : 2'd0;
    assign cnt_after_pop  = q_cnt_reg - 2'(pop);
    assign head_after_pop = q_head_reg ^ pop;
    assign tail           = head_after_pop ^ cnt_after_pop[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg  <= 2'd0;
            q_head_reg <= 1'b0;
        end
        else
        begin
            q_cnt_reg  <= cnt_after_pop + n_new;
            q_head_reg <= head_after_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_new != 2'd0)
        begin
            q_tok_reg[tail] <= r_tok[0];
            q_se_reg[tail]  <= il_reg && !r_v[1];
            q_rl_reg[tail]  <= !r_v[1];
        end
        if (n_new == 2'd2)
        begin
            q_tok_reg[!tail] <= r_tok[1];
            q_se_reg[!tail]  <= il_reg;
            q_rl_reg[!tail]  <= 1'b1;
        end
    end

    assign out_valid     = q_cnt_reg != 2'd0;
    assign token_kind    = q_tok_reg[q_head_reg].kind;
    assign token_class   = q_tok_reg[q_head_reg].group;
    assign text_start    = q_tok_reg[q_head_reg].start;
    assign text_length   = q_tok_reg[q_head_reg].length;
    assign error_code    = q_tok_reg[q_head_reg].err;
    assign statement_end = q_se_reg[q_head_reg];
    assign run_last      = q_rl_reg[q_head_reg];

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2) else $error("queue overflow");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        process |-> (cnt_after_pop + n_new) <= 2'd2) else $error("queue overrun");

    a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (process && il_reg) |=> (bpos_reg == '0 && mode_reg == sqt_pkg::M_IDLE))
        else $error("no return to idle");

    a_se_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && statement_end) |-> run_last) else $error("statement end not last");

endmodule
